### src/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int DefaultWidth = 32;
    localparam int MaxResults   = 32;

    localparam logic [1:0] StatFactor = 2'd0;
    localparam logic [1:0] StatOne    = 2'd1;
    localparam logic [1:0] StatZero   = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_TWO   = 6'b000100,
        S_DIV   = 6'b001000,
        S_CHECK = 6'b010000,
        S_FINAL = 6'b100000
    } t_state;

endpackage

### src/trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization of one unsigned word by trial division.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word i_value. The block holds
// o_stall high from the cycle after a word is taken until its last result
// is loaded into the output register, so one word is factored at a time.
// Output channel: o_valid / i_stall carry one result word per prime factor
// (o_factor, o_last, o_status), in nondecreasing order with repeats; o_last
// marks the final word. Value one gives a single word with status 1, value
// zero a single word with status 2, both with factor zero.
// Operation: factors of two are stripped first by shifting. Each odd trial
// divisor runs a shared restoring divider, one quotient bit per cycle,
// then a check state: a zero remainder gives the divisor as a factor and
// divides again, a nonzero one moves on to the next odd divisor, and once
// the divisor exceeds the quotient, the rest of the value is the last factor.
// Trial divisors run up to about sqrt(value). Zero and one give their word
// before any division, an odd value only after its first full trial.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. While the receiver stalls, the result register holds
// and the sequencer waits before placing the next result.
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
    parameter int WIDTH = tdf_pkg::DefaultWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_factor,
    output logic             o_last,
    output logic [1:0]       o_status
);

    localparam int CntW = $clog2(WIDTH);
    localparam int NW   = $clog2(tdf_pkg::MaxResults + 1);

    tdf_pkg::t_state r_state, n_state;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_d, n_d;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [NW-1:0]    r_n, n_n;

    logic             r_out_valid;
    logic [WIDTH-1:0] r_factor;
    logic             r_last;
    logic [1:0]       r_status;

    logic             w_emit_ok;
    logic             w_emit;
    logic [WIDTH-1:0] w_efac;
    logic             w_elast;
    logic [1:0]       w_estat;
    logic [WIDTH:0]   w_rem_sh;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic             w_cap;

    assign w_emit_ok = !r_out_valid || !i_stall;
    assign w_rem_sh  = {r_rem, r_quo[WIDTH-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_d};
    assign w_ge      = (w_rem_sh >= {1'b0, r_d});
    assign w_cap     = (r_n == NW'(tdf_pkg::MaxResults - 1));

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_d     = r_d;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_n     = r_n;
        w_emit  = 1'b0;
        w_efac  = '0;
        w_elast = 1'b0;
        w_estat = tdf_pkg::StatFactor;
        case (r_state)
            tdf_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_x     = i_value;
                    n_n     = '0;
                    n_state = tdf_pkg::S_START;
                end
            end
            tdf_pkg::S_START: begin
                if (r_x == '0 || r_x == WIDTH'(1)) begin
                    if (w_emit_ok) begin
                        w_emit  = 1'b1;
                        w_elast = 1'b1;
                        w_estat = (r_x == '0) ? tdf_pkg::StatZero : tdf_pkg::StatOne;
                        n_state = tdf_pkg::S_IDLE;
                    end
                end else begin
                    n_state = tdf_pkg::S_TWO;
                end
            end
            tdf_pkg::S_TWO: begin
                if (!r_x[0]) begin
                    if (w_emit_ok) begin
                        w_emit  = 1'b1;
                        w_efac  = WIDTH'(2);
                        w_elast = (r_x == WIDTH'(2)) || w_cap;
                        n_x     = r_x >> 1;
                        n_n     = r_n + NW'(1);
                        if (w_elast) begin
                            n_state = tdf_pkg::S_IDLE;
                        end
                    end
                end else begin
                    n_d     = WIDTH'(3);
                    n_rem   = '0;
                    n_quo   = r_x;
                    n_cnt   = CntW'(WIDTH - 1);
                    n_state = tdf_pkg::S_DIV;
                end
            end
            tdf_pkg::S_DIV: begin
                n_rem = w_ge ? w_diff[WIDTH-1:0] : w_rem_sh[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = tdf_pkg::S_CHECK;
                end else begin
                    n_cnt = r_cnt - CntW'(1);
                end
            end
            tdf_pkg::S_CHECK: begin
                if (r_d <= r_quo) begin
                    if (r_rem == '0) begin
                        if (w_emit_ok) begin
                            w_emit  = 1'b1;
                            w_efac  = r_d;
                            w_elast = w_cap;
                            n_x     = r_quo;
                            n_n     = r_n + NW'(1);
                            if (w_cap) begin
                                n_state = tdf_pkg::S_IDLE;
                            end else begin
                                n_rem   = '0;
                                n_quo   = r_quo;
                                n_cnt   = CntW'(WIDTH - 1);
                                n_state = tdf_pkg::S_DIV;
                            end
                        end
                    end else begin
                        n_d     = r_d + WIDTH'(2);
                        n_rem   = '0;
                        n_quo   = r_x;
                        n_cnt   = CntW'(WIDTH - 1);
                        n_state = tdf_pkg::S_DIV;
                    end
                end else begin
                    n_state = tdf_pkg::S_FINAL;
                end
            end
            tdf_pkg::S_FINAL: begin
                if (w_emit_ok) begin
                    w_emit  = 1'b1;
                    w_efac  = r_x;
                    w_elast = 1'b1;
                    n_state = tdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_n   <= n_n;
        if (w_emit) begin
            r_factor <= w_efac;
            r_last   <= w_elast;
            r_status <= w_estat;
        end
    end

    assign o_stall  = (r_state != tdf_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_factor = r_factor;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule
